/* hdl/mkat_pkg.sv */
// Package: shared types and constants of the multi-key autorepeat timer.
package mkat_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned ElapsedW = 12;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgW-1:0] InitDelayRst = 16'd500;
  localparam logic [CfgW-1:0] IntervalRst  = 16'd100;

  typedef enum logic [CmdW-1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_DELAY = 1'b0,
    CFG_INTERVAL   = 1'b1
  } cfg_idx_e;

  // One code's stored timing state.
  typedef struct packed {
    logic              repeating;
    logic [TimerW-1:0] timer;
  } entry_t;

endpackage

/* hdl/mkat_if.sv */
// Interfaces: request and result channels of the autorepeat timer.
interface mkat_req_if;
  logic                            valid;
  logic                            ready;
  logic [mkat_pkg::CmdW-1:0]       command;
  logic [mkat_pkg::CodeW-1:0]      action_code;
  logic [mkat_pkg::ElapsedW-1:0]   elapsed_ms;

  modport source (output valid, command, action_code, elapsed_ms, input ready);
  modport sink   (input valid, command, action_code, elapsed_ms, output ready);
endinterface

interface mkat_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       repeat_fired;
  logic [mkat_pkg::CodeW-1:0] repeat_code;

  modport source (output valid, repeat_fired, repeat_code, input ready);
  modport sink   (input valid, repeat_fired, repeat_code, output ready);
endinterface

/* hdl/mkat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mkat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/multi_key_autorepeat_timer_core.sv */
// Top level: typematic autorepeat timer for a small set of action codes.
//
// Usage:
//   req_i carries one request per handshake: a press or release of an
//   action code, or a time tick with the milliseconds elapsed since the
//   previous tick. Code 0 and codes at or above NUM_CODES are ignored.
//   rsp_o returns exactly one result per request: repeat_fired and
//   repeat_code report the code that fired on a tick, zero otherwise.
//   cfg_we_i/cfg_idx_i/cfg_data_i write initial_delay (index 0) and
//   repeat_interval (index 1); write them only while the block is idle.
// Sequence:
//   Press, release or an unknown command: the request goes through the
//   S_DELIVER state into the result register, and a new request is taken
//   once that result is registered and the block is back in idle.
//   Tick: the walk visits one code per cycle through the state RAM, from
//   code 1 up to the first code that fires or the last code, then delivers.
//   The RAM's single read port and its registered read data set this rate.
// Reset:
//   All codes are released (held flags in flops are cleared at once, the
//   RAM needs no clearing pass), delays return to 500 ms and 100 ms.
// Stalls:
//   The result register parts the two sides; a request can be taken and
//   worked on while a result waits, and the next result waits internally
//   until the receiver takes the previous one.
module multi_key_autorepeat_timer_core #(
  parameter int unsigned NUM_CODES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mkat_req_if.sink                            req_i,
  mkat_rsp_if.source                          rsp_o,
  input  logic                                cfg_we_i,
  input  logic [mkat_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mkat_pkg::CfgW-1:0]           cfg_data_i
);

  localparam int unsigned CW = $clog2(NUM_CODES);
  localparam int unsigned EW = $bits(mkat_pkg::entry_t);
  localparam int unsigned TW = mkat_pkg::TimerW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DELIVER
  } state_e;

  state_e                         state_q;
  logic [NUM_CODES-1:0]           held_q;
  logic [CW-1:0]                  cur_q;
  logic [mkat_pkg::CfgW-1:0]      init_q, intv_q;
  logic                           res_fired_q;
  logic [mkat_pkg::CodeW-1:0]     res_code_q;
  logic                           out_vld_q, out_fired_q;
  logic [mkat_pkg::CodeW-1:0]     out_code_q;
  logic [mkat_pkg::ElapsedW-1:0]  req_elapsed_q;

  logic                           req_acc;
  mkat_pkg::cmd_e                 cmd;
  logic                           code_ok;
  logic [CW-1:0]                  code_idx;
  logic                           out_free;

  logic                           ram_we, ram_re;
  logic [CW-1:0]                  ram_waddr, ram_raddr;
  mkat_pkg::entry_t               ram_wdata, ram_rdata;
  logic [EW-1:0]                  ram_rdata_raw;

  logic [TW:0]                    t_sum;
  logic [TW-1:0]                  t_sat, thr;
  logic                           fire, cur_held, walk_last;

  // Request decode.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cmd         = mkat_pkg::cmd_e'(req_i.command);
  assign code_ok     = (req_i.action_code != '0) && (32'(req_i.action_code) < NUM_CODES);
  assign code_idx    = CW'(req_i.action_code);
  assign out_free    = !out_vld_q || rsp_o.ready;

  // Timer arithmetic for the code under the walk.
  assign ram_rdata = mkat_pkg::entry_t'(ram_rdata_raw);
  assign cur_held  = held_q[cur_q];
  assign t_sum     = {1'b0, ram_rdata.timer} + (TW+1)'(req_elapsed_q);
  assign t_sat     = t_sum[TW] ? '1 : t_sum[TW-1:0];
  assign thr       = ram_rdata.repeating ? intv_q : init_q;
  assign fire      = cur_held && (t_sat >= thr);
  assign walk_last = (cur_q == CW'(NUM_CODES - 1));

  // RAM control: press writes a fresh entry, the walk writes back held codes.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = code_idx;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = CW'(1);
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (cmd == mkat_pkg::CMD_PRESS && code_ok && !held_q[code_idx]) begin
            ram_we = 1'b1;
          end
          if (cmd == mkat_pkg::CMD_TICK) begin
            ram_re = 1'b1;
          end
        end
      end
      S_WALK: begin
        ram_waddr = cur_q;
        ram_we    = cur_held;
        ram_wdata.repeating = ram_rdata.repeating || fire;
        ram_wdata.timer     = fire ? (t_sat - thr) : t_sat;
        ram_raddr = CW'(cur_q + 1'b1);
        ram_re    = !fire && !walk_last;
      end
      S_DELIVER: begin
      end
      default: begin
      end
    endcase
  end

  mkat_ram #(
    .Width (EW),
    .Depth (NUM_CODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // Sequencer, held flags, configuration and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      held_q        <= '0;
      cur_q         <= CW'(1);
      init_q        <= mkat_pkg::InitDelayRst;
      intv_q        <= mkat_pkg::IntervalRst;
      res_fired_q   <= 1'b0;
      res_code_q    <= '0;
      out_vld_q     <= 1'b0;
      out_fired_q   <= 1'b0;
      out_code_q    <= '0;
      req_elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (mkat_pkg::cfg_idx_e'(cfg_idx_i))
          mkat_pkg::CFG_INIT_DELAY: init_q <= cfg_data_i;
          mkat_pkg::CFG_INTERVAL:   intv_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // Drop the shown result once taken, unless a new one replaces it.
      if (out_vld_q && rsp_o.ready && state_q != S_DELIVER) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            res_fired_q   <= 1'b0;
            res_code_q    <= '0;
            req_elapsed_q <= req_i.elapsed_ms;
            cur_q         <= CW'(1);
            state_q       <= S_DELIVER;
            unique case (cmd)
              mkat_pkg::CMD_PRESS: begin
                if (code_ok) held_q[code_idx] <= 1'b1;
              end
              mkat_pkg::CMD_RELEASE: begin
                if (code_ok) held_q[code_idx] <= 1'b0;
              end
              mkat_pkg::CMD_TICK: begin
                state_q <= S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          // Advance one code per cycle; stop at the first that fires or at the last code.
          if (fire) begin
            res_fired_q <= 1'b1;
            res_code_q  <= mkat_pkg::CodeW'(cur_q);
            state_q     <= S_DELIVER;
          end else if (walk_last) begin
            state_q <= S_DELIVER;
          end else begin
            cur_q <= CW'(cur_q + 1'b1);
          end
        end
        S_DELIVER: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_fired_q <= res_fired_q;
            out_code_q  <= res_code_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.repeat_fired = out_fired_q;
  assign rsp_o.repeat_code  = out_code_q;

  // The walk never visits code 0.
  a_walk_skips_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> cur_q != '0)
    else $error("walk reached code 0");

  // A firing code must be held.
  a_fire_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && fire) |-> held_q[cur_q])
    else $error("unheld code fired");

  // A shown result reports a code exactly when it fired.
  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_fired_q == (out_code_q != '0)))
    else $error("fired flag and code disagree");

  // A valid press leaves its code held.
  a_press_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && cmd == mkat_pkg::CMD_PRESS && code_ok) |=> held_q[$past(code_idx)])
    else $error("pressed code not held");

endmodule
